// ===== design/wcsf_pkg.sv =====
package wcsf_pkg;

	// Word geometry
	localparam int MAX_WORD  = 8;
	localparam int NUM_WORDS = 6;
	localparam int RUN_MAX   = MAX_WORD + 1;
	localparam int LEN_W     = $clog2(MAX_WORD + 1);
	localparam int CNT_W     = $clog2(RUN_MAX + 1);
	localparam int CFG_IDX_W = $clog2(NUM_WORDS);
	localparam int CFG_W     = 64;

	// Byte codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	// Default forbidden words, first byte lowest
	localparam logic [CFG_W-1:0] WORD_0_RST = 64'd7627110;          // fat
	localparam logic [CFG_W-1:0] WORD_1_RST = 64'd5521734;          // FAT
	localparam logic [CFG_W-1:0] WORD_2_RST = 64'd2037147509;       // ugly
	localparam logic [CFG_W-1:0] WORD_3_RST = 64'd1498171221;       // UGLY
	localparam logic [CFG_W-1:0] WORD_4_RST = 64'd110404021089395;  // stupid
	localparam logic [CFG_W-1:0] WORD_5_RST = 64'd75081671070803;   // STUPID

	typedef logic [NUM_WORDS-1:0][CFG_W-1:0] word_set_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       message_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       message_end;
	} out_t;

	// One burst of output bytes caused by a single input transaction
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    last;
	} run_t;

	function automatic logic is_delim(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_COMMA) || (b == CH_DOT) ||
			(b == CH_BANG) || (b == CH_NUL);
	endfunction

endpackage

// ===== design/word_censor_stream_filter.sv =====
// Channel | Handshake           | Payload
// input   | in_valid / in_stall   | in_data  (in_byte, message_last)
// output  | out_valid / out_stall | out_data (out_byte, run_end, message_end)
// config  | cfg_we               | cfg_index, cfg_data (word_0 .. word_5)
//
// One input transaction per cycle while in_stall is low; a byte that only extends the
// current word is taken every cycle regardless of the output side. A delimiter,
// message_last, full word buffer or overflow-state byte makes a burst of up to 9 bytes,
// sent one per cycle unless out_stall holds, from the output shift register; the next
// burst-producing transaction waits in the input register until the last burst byte leaves.
// Reset (arst_n low) empties both registers and restores the default words.
module word_censor_stream_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  wcsf_pkg::in_t                         in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output wcsf_pkg::out_t                        out_data,
	input  logic                                  cfg_we,
	input  logic [wcsf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wcsf_pkg::CFG_W-1:0]            cfg_data
);
	import wcsf_pkg::*;

	in_t       item_s1;
	logic      valid_s1;
	word_set_t words_q;
	logic      emits;
	logic      free;
	logic      consume;
	logic      accept;
	run_t      run;

	// Input register drains when its burst (if any) has somewhere to go
	assign consume  = valid_s1 && (!emits || free);
	assign in_stall = valid_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Forbidden word registers; out-of-range index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q[0] <= WORD_0_RST;
			words_q[1] <= WORD_1_RST;
			words_q[2] <= WORD_2_RST;
			words_q[3] <= WORD_3_RST;
			words_q[4] <= WORD_4_RST;
			words_q[5] <= WORD_5_RST;
		end else begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				if (cfg_we && (cfg_index == CFG_IDX_W'(i))) begin
					words_q[i] <= cfg_data;
				end
			end
		end
	end

	wcsf_word_unit u_word (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.take   (consume),
		.words  (words_q),
		.emits  (emits),
		.run    (run)
	);

	wcsf_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (consume && emits),
		.run       (run),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== design/wcsf_word_unit.sv =====
module wcsf_word_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  wcsf_pkg::in_t      item,
	input  logic               take,
	input  wcsf_pkg::word_set_t words,
	output logic               emits,
	output wcsf_pkg::run_t     run
);
	import wcsf_pkg::*;

	logic [MAX_WORD-1:0][7:0] buf_q;
	logic [LEN_W-1:0]         len_q;
	logic                     ovf_q;

	logic                     delim;
	logic                     full;
	logic                     hit;
	logic [NUM_WORDS-1:0]     word_eq;
	logic [MAX_WORD*8-1:0]    packed_word;

	assign delim = item.message_last || is_delim(item.in_byte);
	assign full  = (len_q == LEN_W'(MAX_WORD));
	assign emits = delim || ovf_q || full;

	// Current word, zero padded past its length
	always_comb begin
		for (int i = 0; i < MAX_WORD; i++) begin
			packed_word[i*8 +: 8] = (LEN_W'(i) < len_q) ? buf_q[i] : 8'h00;
		end
	end

	// Compare against every configured word at once
	always_comb begin
		for (int w = 0; w < NUM_WORDS; w++) begin
			word_eq[w] = (words[w] != '0) &&
				(words[w] == CFG_W'(packed_word));
		end
	end

	// Overflow state always has an empty buffer, so it never hits
	assign hit = delim && !ovf_q && (len_q != '0) && (|word_eq);

	// Buffered bytes (or stars), then the incoming byte
	always_comb begin
		for (int i = 0; i < RUN_MAX; i++) begin
			if (CNT_W'(i) < CNT_W'(len_q)) begin
				run.bytes[i] = hit ? CH_STAR : buf_q[i];
			end else if (CNT_W'(i) == CNT_W'(len_q)) begin
				run.bytes[i] = item.in_byte;
			end else begin
				run.bytes[i] = 8'h00;
			end
		end
		run.cnt  = CNT_W'(len_q) + CNT_W'(1);
		run.last = item.message_last;
	end

	// Word buffer: payload only
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_WORD; i++) begin
			if (take && !emits && (len_q == LEN_W'(i))) begin
				buf_q[i] <= item.in_byte;
			end
		end
	end

	// Length and passthrough state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (take) begin
			if (!emits) begin
				len_q <= len_q + LEN_W'(1);
			end else begin
				len_q <= '0;
				if (delim) begin
					ovf_q <= 1'b0;
				end else if (full) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/wcsf_serializer.sv =====
module wcsf_serializer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  wcsf_pkg::run_t run,
	output logic           free,
	output logic           out_valid,
	input  logic           out_stall,
	output wcsf_pkg::out_t out_data
);
	import wcsf_pkg::*;

	logic [RUN_MAX-1:0][7:0] bytes_q;
	logic [CNT_W-1:0]        rem_q;
	logic                    last_q;
	logic                    fire;

	assign out_valid = (rem_q != '0);
	assign fire      = out_valid && !out_stall;
	// Free once the final byte of the current burst leaves
	assign free      = (rem_q == '0) || (fire && (rem_q == CNT_W'(1)));

	assign out_data.out_byte    = bytes_q[0];
	assign out_data.run_end     = (rem_q == CNT_W'(1));
	assign out_data.message_end = (rem_q == CNT_W'(1)) && last_q;

	// Burst bytes shift down as each one is taken
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= run.bytes;
			last_q  <= run.last;
		end else if (fire) begin
			bytes_q <= {8'h00, bytes_q[RUN_MAX-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= run.cnt;
		end else if (fire) begin
			rem_q <= rem_q - CNT_W'(1);
		end
	end

endmodule
